// ===== src/rbap_pkg.sv =====
// ----------------------------------------------------------------------------
// rbap_pkg
// Shared codes, characters and result types of the bulk array request parser.
// ----------------------------------------------------------------------------
package rbap_pkg;

   // characters of the wire format
   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_PLUS   = 8'h2B;
   localparam logic [7:0] CHAR_MINUS  = 8'h2D;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;

   // number magnitude saturates here, above any register limit
   localparam logic [31:0] NUM_CAP = 32'h8000_0000;

   // result kinds
   localparam logic [1:0] KIND_BYTE  = 2'd0;
   localparam logic [1:0] KIND_EMPTY = 2'd1;
   localparam logic [1:0] KIND_DONE  = 2'd2;
   localparam logic [1:0] KIND_ERROR = 2'd3;

   // status codes
   localparam logic [2:0] STATUS_OK          = 3'd0;
   localparam logic [2:0] STATUS_NO_STAR     = 3'd1;
   localparam logic [2:0] STATUS_BAD_COUNT   = 3'd2;
   localparam logic [2:0] STATUS_COUNT_RANGE = 3'd3;
   localparam logic [2:0] STATUS_NO_DOLLAR   = 3'd4;
   localparam logic [2:0] STATUS_BAD_LENGTH  = 3'd5;
   localparam logic [2:0] STATUS_LENGTH_RANGE = 3'd6;
   localparam logic [2:0] STATUS_INCOMPLETE  = 3'd7;

   // configuration register indexes and reset values
   localparam logic CSR_MAX_ARGUMENTS       = 1'b0;
   localparam logic CSR_MAX_ARGUMENT_LENGTH = 1'b1;
   localparam logic [15:0] MAX_ARGUMENTS_RESET       = 16'd1024;
   localparam logic [29:0] MAX_ARGUMENT_LENGTH_RESET = 30'd536870912;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  arg_byte;
      logic [15:0] arg_index;
      logic [28:0] byte_offset;
      logic        arg_final;
      logic [2:0]  status;
      logic [31:0] consumed;
      logic [15:0] arg_total;
      logic        last;
   } result_type;

   // up to two results written per accepted item
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

   typedef struct packed {
      logic not_empty;
      logic room_two;
   } fifo_status_type;

endpackage

// ===== src/rbap_req_if.sv =====
// ----------------------------------------------------------------------------
// rbap_req_if
// Request byte channel: one byte and its end-of-buffer mark per item.
// ----------------------------------------------------------------------------
interface rbap_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       buffer_end;

   modport source (output valid, output data_byte, output buffer_end, input ready);
   modport sink   (input valid, input data_byte, input buffer_end, output ready);
endinterface

// ===== src/rbap_rsp_if.sv =====
// ----------------------------------------------------------------------------
// rbap_rsp_if
// Result channel: argument bytes, empty arguments, done and error reports.
// ----------------------------------------------------------------------------
interface rbap_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  arg_byte;
   logic [15:0] arg_index;
   logic [28:0] byte_offset;
   logic        arg_final;
   logic [2:0]  status;
   logic [31:0] consumed;
   logic [15:0] arg_total;
   logic        last;

   modport source (output valid, output kind, output arg_byte, output arg_index,
                   output byte_offset, output arg_final, output status,
                   output consumed, output arg_total, output last, input ready);
   modport sink   (input valid, input kind, input arg_byte, input arg_index,
                   input byte_offset, input arg_final, input status,
                   input consumed, input arg_total, input last, output ready);
endinterface

// ===== src/rbap_result_fifo.sv =====
// ----------------------------------------------------------------------------
// rbap_result_fifo
// Small result queue; takes up to two results a cycle, gives one.
// ----------------------------------------------------------------------------
module rbap_result_fifo #(
   parameter int DEPTH = 4   // power of two, 2 or more
) (
   input  logic                     clock,
   input  logic                     reset,
   input  rbap_pkg::push_type       push,
   input  logic                     pop,
   output rbap_pkg::result_type     head,
   output rbap_pkg::fifo_status_type status
);
   import rbap_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   result_type      slot_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [PW-1:0]   wr_next;

   assign wr_next   = wr_ptr_ff + 1'b1;
   assign wr_ptr_in = wr_ptr_ff + PW'(push.count);
   assign rd_ptr_in = rd_ptr_ff + PW'(pop);
   assign count_in  = count_ff + CW'(push.count) - CW'(pop);

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         slot_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         slot_ff[wr_next] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign head             = slot_ff[rd_ptr_ff];
   assign status.not_empty = (count_ff != '0);
   assign status.room_two  = (count_ff <= CW'(DEPTH - 2));

endmodule

// ===== src/resp_bulk_array_request_parser.sv =====
// ----------------------------------------------------------------------------
// resp_bulk_array_request_parser
// Streaming parser for requests made of an array of bulk strings.
// ----------------------------------------------------------------------------
//
//   channel   dir   handshake            payload
//   req_ch    in    valid / ready        data_byte, buffer_end
//   rsp_ch    out   valid / ready        kind .. last (up to two results per item)
//   csr_*     in    csr_write_enable     csr_index, csr_write_data
//
// One request byte per cycle while req_ch.ready is high. Each accepted byte updates the parser state in
// the same cycle and writes its zero, one or two results into the result
// queue; results are registered there and appear on rsp_ch in order.
// req_ch.ready drops only while the queue lacks room for two results, so a
// stalled rsp_ch throttles input after a few items.
// Reset clears the parser, the queue and loads the register defaults.
//
module resp_bulk_array_request_parser #(
   parameter int LINE_LIMIT   = 32,  // 4 .. 64 characters per number line
   parameter int RESULT_DEPTH = 4    // power of two, 2 or more
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [29:0] csr_write_data,
   rbap_req_if.sink    req_ch,
   rbap_rsp_if.source  rsp_ch
);
   import rbap_pkg::*;

   localparam int CHW = $clog2(LINE_LIMIT + 1);

   typedef enum logic [2:0] {
      PH_IDLE, PH_COUNT, PH_DOLLAR, PH_LEN, PH_DATA, PH_SKIP1, PH_SKIP2, PH_DROP
   } phase_type;

   typedef enum logic [1:0] {LINE_MORE, LINE_DONE, LINE_LONG} line_type;

   // number being read from the current line
   typedef struct packed {
      logic [31:0]    acc;
      logic           neg;
      logic           stopped;
      logic           begun;
      logic [CHW-1:0] chars;
   } num_type;

   // atoi-style character step; chars counts every line character
   function automatic num_type absorb(num_type s, logic [7:0] c);
      num_type     r;
      logic [34:0] prod;
      logic [7:0]  digit;
      r     = s;
      digit = c - CHAR_ZERO;
      prod  = {3'b000, s.acc} * 35'd10 + {27'd0, digit};
      r.chars = s.chars + 1'b1;
      if (!s.stopped) begin
         if (c inside {[CHAR_ZERO:CHAR_NINE]}) begin
            r.acc   = (prod > {3'b000, NUM_CAP}) ? NUM_CAP : prod[31:0];
            r.begun = 1'b1;
         end else if (!s.begun && (c == CHAR_SPACE || c inside {[CHAR_TAB:CHAR_CR]})) begin
            r.begun = 1'b0;  // leading white space
         end else if (!s.begun && (c == CHAR_PLUS || c == CHAR_MINUS)) begin
            r.begun = 1'b1;
            r.neg   = (c == CHAR_MINUS);
         end else begin
            r.stopped = 1'b1;
         end
      end
      return r;
   endfunction

   function automatic logic out_of_range(num_type s, logic [31:0] limit);
      return (s.neg && s.acc != 32'd0) || (s.acc > limit);
   endfunction

   // configuration
   logic [15:0] max_arguments_ff;
   logic [29:0] max_arg_length_ff;

   // parser state
   phase_type   phase_ff, phase_in;
   num_type     num_ff, num_in;
   logic        pending_cr_ff, pending_cr_in;
   logic [15:0] arg_count_ff, arg_count_in;
   logic [15:0] cur_arg_ff, cur_arg_in;
   logic [29:0] bytes_left_ff, bytes_left_in;
   logic [29:0] arg_length_ff, arg_length_in;
   logic [31:0] request_bytes_ff, request_bytes_in;

   // line step results
   num_type     line_num;
   logic        line_pcr;
   line_type    line_res;

   // per-item results
   logic        accept;
   logic        a_valid;
   result_type  a_res;
   logic        e_valid;
   logic [2:0]  e_code;
   result_type  e_res;
   logic [31:0] bumped;
   logic [29:0] bl_dec;
   logic [29:0] offset;
   logic [15:0] cur_next;
   push_type    push;
   result_type  head;
   fifo_status_type fifo_status;

   logic [7:0]  b;
   logic        at_end;

   assign b      = req_ch.data_byte;
   assign at_end = req_ch.buffer_end;
   assign accept = req_ch.valid & req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_arguments_ff  <= MAX_ARGUMENTS_RESET;
         max_arg_length_ff <= MAX_ARGUMENT_LENGTH_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_MAX_ARGUMENTS:       max_arguments_ff  <= csr_write_data[15:0];
            CSR_MAX_ARGUMENT_LENGTH: max_arg_length_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // number line step: CR LF ends a line, a lone CR counts as a character
   always_comb begin
      line_num = num_ff;
      line_pcr = pending_cr_ff;
      line_res = LINE_MORE;
      if (pending_cr_ff) begin
         line_pcr = 1'b0;
         if (b == CHAR_LF) begin
            line_res = LINE_DONE;
         end else begin
            line_num = absorb(line_num, CHAR_CR);
            if (line_num.chars >= CHW'(LINE_LIMIT)) begin
               line_res = LINE_LONG;
            end
         end
      end
      if (line_res == LINE_MORE) begin
         if (b == CHAR_CR) begin
            line_pcr = 1'b1;
         end else begin
            line_num = absorb(line_num, b);
            if (line_num.chars >= CHW'(LINE_LIMIT)) begin
               line_res = LINE_LONG;
            end
         end
      end
   end

   assign bumped   = (request_bytes_ff == 32'hFFFF_FFFF) ? request_bytes_ff
                                                         : request_bytes_ff + 32'd1;
   assign bl_dec   = (bytes_left_ff != 30'd0) ? bytes_left_ff - 30'd1 : bytes_left_ff;
   assign offset   = arg_length_ff - bytes_left_ff;
   assign cur_next = cur_arg_ff + 16'd1;

   always_comb begin
      phase_in         = phase_ff;
      num_in           = num_ff;
      pending_cr_in    = pending_cr_ff;
      arg_count_in     = arg_count_ff;
      cur_arg_in       = cur_arg_ff;
      bytes_left_in    = bytes_left_ff;
      arg_length_in    = arg_length_ff;
      request_bytes_in = request_bytes_ff;
      a_valid          = 1'b0;
      a_res            = '0;
      e_valid          = 1'b0;
      e_code           = STATUS_OK;

      case (phase_ff)
         PH_IDLE: begin
            request_bytes_in = 32'd1;
            arg_count_in     = 16'd0;
            cur_arg_in       = 16'd0;
            if (b != CHAR_STAR) begin
               e_valid = 1'b1;
               e_code  = STATUS_NO_STAR;
            end else begin
               num_in        = '0;
               pending_cr_in = 1'b0;
               phase_in      = PH_COUNT;
               if (at_end) begin
                  e_valid = 1'b1;
                  e_code  = STATUS_BAD_COUNT;
               end
            end
         end
         PH_COUNT: begin
            request_bytes_in = bumped;
            num_in           = line_num;
            pending_cr_in    = line_pcr;
            if (line_res == LINE_LONG) begin
               e_valid = 1'b1;
               e_code  = STATUS_BAD_COUNT;
            end else if (line_res == LINE_DONE) begin
               if (out_of_range(num_ff, {16'd0, max_arguments_ff})) begin
                  e_valid = 1'b1;
                  e_code  = STATUS_COUNT_RANGE;
               end else begin
                  arg_count_in = num_ff.acc[15:0];
                  cur_arg_in   = 16'd0;
                  if (num_ff.acc == 32'd0) begin
                     // zero count: done on the LF
                     a_valid        = 1'b1;
                     a_res.kind     = KIND_DONE;
                     a_res.consumed = bumped;
                     phase_in       = PH_IDLE;
                  end else if (at_end) begin
                     e_valid = 1'b1;
                     e_code  = STATUS_NO_DOLLAR;
                  end else begin
                     phase_in = PH_DOLLAR;
                  end
               end
            end else if (at_end) begin
               e_valid = 1'b1;
               e_code  = STATUS_BAD_COUNT;
            end
         end
         PH_DOLLAR: begin
            request_bytes_in = bumped;
            if (b != CHAR_DOLLAR) begin
               e_valid = 1'b1;
               e_code  = STATUS_NO_DOLLAR;
            end else begin
               num_in        = '0;
               pending_cr_in = 1'b0;
               phase_in      = PH_LEN;
               if (at_end) begin
                  e_valid = 1'b1;
                  e_code  = STATUS_BAD_LENGTH;
               end
            end
         end
         PH_LEN: begin
            request_bytes_in = bumped;
            num_in           = line_num;
            pending_cr_in    = line_pcr;
            if (line_res == LINE_LONG) begin
               e_valid = 1'b1;
               e_code  = STATUS_BAD_LENGTH;
            end else if (line_res == LINE_DONE) begin
               if (out_of_range(num_ff, {2'b00, max_arg_length_ff})) begin
                  e_valid = 1'b1;
                  e_code  = STATUS_LENGTH_RANGE;
               end else if (at_end) begin
                  e_valid = 1'b1;
                  e_code  = STATUS_INCOMPLETE;
               end else begin
                  arg_length_in = num_ff.acc[29:0];
                  bytes_left_in = num_ff.acc[29:0];
                  if (num_ff.acc == 32'd0) begin
                     a_valid         = 1'b1;
                     a_res.kind      = KIND_EMPTY;
                     a_res.arg_index = cur_arg_ff;
                     phase_in        = PH_SKIP1;
                  end else begin
                     phase_in = PH_DATA;
                  end
               end
            end else if (at_end) begin
               e_valid = 1'b1;
               e_code  = STATUS_BAD_LENGTH;
            end
         end
         PH_DATA: begin
            request_bytes_in  = bumped;
            bytes_left_in     = bl_dec;
            a_valid           = 1'b1;
            a_res.kind        = KIND_BYTE;
            a_res.arg_byte    = b;
            a_res.arg_index   = cur_arg_ff;
            a_res.byte_offset = offset[28:0];
            a_res.arg_final   = (bl_dec == 30'd0);
            if (bl_dec == 30'd0) begin
               phase_in = PH_SKIP1;
            end
            if (at_end) begin
               e_valid = 1'b1;
               e_code  = STATUS_INCOMPLETE;
            end
         end
         PH_SKIP1: begin
            request_bytes_in = bumped;
            phase_in         = PH_SKIP2;
            if (at_end) begin
               e_valid = 1'b1;
               e_code  = STATUS_INCOMPLETE;
            end
         end
         PH_SKIP2: begin
            request_bytes_in = bumped;
            cur_arg_in       = cur_next;
            if (cur_next >= arg_count_ff) begin
               a_valid         = 1'b1;
               a_res.kind      = KIND_DONE;
               a_res.consumed  = bumped;
               a_res.arg_total = arg_count_ff;
               phase_in        = PH_IDLE;
            end else if (at_end) begin
               e_valid = 1'b1;
               e_code  = STATUS_NO_DOLLAR;
            end else begin
               phase_in = PH_DOLLAR;
            end
         end
         PH_DROP: begin
            if (at_end) begin
               phase_in = PH_IDLE;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase

      // an error resyncs on the end mark
      if (e_valid) begin
         phase_in = at_end ? PH_IDLE : PH_DROP;
      end
   end

   always_comb begin
      e_res        = '0;
      e_res.kind   = KIND_ERROR;
      e_res.status = e_code;
      e_res.last   = 1'b1;
      push         = '0;
      if (accept) begin
         if (a_valid && e_valid) begin
            push.count  = 2'd2;
            push.first  = a_res;
            push.second = e_res;
         end else if (a_valid) begin
            push.count      = 2'd1;
            push.first      = a_res;
            push.first.last = 1'b1;
         end else if (e_valid) begin
            push.count = 2'd1;
            push.first = e_res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_IDLE;
         num_ff           <= '0;
         pending_cr_ff    <= 1'b0;
         arg_count_ff     <= 16'd0;
         cur_arg_ff       <= 16'd0;
         bytes_left_ff    <= 30'd0;
         arg_length_ff    <= 30'd0;
         request_bytes_ff <= 32'd0;
      end else if (accept) begin
         phase_ff         <= phase_in;
         num_ff           <= num_in;
         pending_cr_ff    <= pending_cr_in;
         arg_count_ff     <= arg_count_in;
         cur_arg_ff       <= cur_arg_in;
         bytes_left_ff    <= bytes_left_in;
         arg_length_ff    <= arg_length_in;
         request_bytes_ff <= request_bytes_in;
      end
   end

   rbap_result_fifo #(
      .DEPTH (RESULT_DEPTH)
   ) u_result_fifo (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .pop    (rsp_ch.valid & rsp_ch.ready),
      .head   (head),
      .status (fifo_status)
   );

   assign req_ch.ready       = fifo_status.room_two;
   assign rsp_ch.valid       = fifo_status.not_empty;
   assign rsp_ch.kind        = head.kind;
   assign rsp_ch.arg_byte    = head.arg_byte;
   assign rsp_ch.arg_index   = head.arg_index;
   assign rsp_ch.byte_offset = head.byte_offset;
   assign rsp_ch.arg_final   = head.arg_final;
   assign rsp_ch.status      = head.status;
   assign rsp_ch.consumed    = head.consumed;
   assign rsp_ch.arg_total   = head.arg_total;
   assign rsp_ch.last        = head.last;

endmodule

// ===== src/rbap_checker.sv =====
// ----------------------------------------------------------------------------
// rbap_checker
// Port-level checks of the parser's result channel, bound to the top level.
// ----------------------------------------------------------------------------
module rbap_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_kind,
   input logic [7:0]  rsp_arg_byte,
   input logic [15:0] rsp_arg_index,
   input logic [28:0] rsp_byte_offset,
   input logic [2:0]  rsp_status,
   input logic [31:0] rsp_consumed,
   input logic        rsp_last
);
   import rbap_pkg::*;

   // nothing is offered right after reset
   a_quiet_after_reset: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("result offered right after reset");

   // a result is held until taken
   a_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn before taken");

   a_payload_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_kind) && $stable(rsp_arg_byte)
         && $stable(rsp_arg_index) && $stable(rsp_byte_offset)
         && $stable(rsp_status) && $stable(rsp_consumed) && $stable(rsp_last))
      else $error("stalled result changed");

   // the only byte with two results is a data byte cut off by the end mark
   a_pair_is_incomplete: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=>
         rsp_valid && rsp_kind == KIND_ERROR && rsp_status == STATUS_INCOMPLETE
         && rsp_last)
      else $error("first of two results not followed by incomplete error");

   a_pair_starts_with_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_kind == KIND_BYTE)
      else $error("non-final result is not a data byte");

endmodule

bind resp_bulk_array_request_parser rbap_checker u_rbap_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_kind        (rsp_ch.kind),
   .rsp_arg_byte    (rsp_ch.arg_byte),
   .rsp_arg_index   (rsp_ch.arg_index),
   .rsp_byte_offset (rsp_ch.byte_offset),
   .rsp_status      (rsp_ch.status),
   .rsp_consumed    (rsp_ch.consumed),
   .rsp_last        (rsp_ch.last)
);
